// File: rtl/lru_pkg.sv
// shared types and constants for the lru page replacement block
package lru_pkg;

  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;

  localparam int REF_W   = 16;
  localparam int LIMIT_W = 4;
  localparam int COUNT_W = 4;
  localparam int FAULT_W = 32;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 56;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

  // controller to datapath
  typedef struct packed {
    logic load;    // latch reference, restart scan
    logic scan;    // one frame per cycle through the page store
    logic commit;  // update state and load the output register
  } lru_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } lru_status_t;

endpackage

// File: rtl/lru_page_replacement.sv
// top level of the lru page replacement block
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata[15:0] page_ref
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata: hit, evicted_valid, evicted_page,
//                                                 resident_count, fault_total, zero fill
//  cfg       in   cfg_wr_en                       cfg_wr_data[3:0] frame_limit
//
//  a hit stops the scan at its recency position, a miss walks the whole list; the scan
//  reads one frame a cycle through the single read port of the page store
//  sync reset clears counts, sets the recency list to identity and frame_limit to 8;
//  the page store is not cleared
//  the output register holds a result while the next reference is accepted and scanned;
//  commit of that reference waits until the output register is free
module lru_page_replacement
  import lru_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [IN_W-1:0]    s_axis_tdata,   // page_ref
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [OUT_W-1:0]   m_axis_tdata,   // hit, evicted_valid, evicted_page[15:0],
                                             // resident_count[3:0], fault_total[31:0]
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data
);

  lru_cmd_t    cmd;
  lru_status_t status;

  lru_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  lru_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .page_ref      (s_axis_tdata[REF_W-1:0]),
    .cmd           (cmd),
    .status        (status),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: rtl/lru_ctrl.sv
// controller state machine: accept, scan, commit
module lru_ctrl
  import lru_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  lru_status_t status,
  output lru_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (status.scan_done) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign cmd.load      = (state == S_IDLE) && s_axis_tvalid;
  assign cmd.scan      = (state == S_SCAN);
  assign cmd.commit    = (state == S_COMMIT) && status.out_free;

endmodule

// File: rtl/lru_datapath.sv
// datapath: page store, recency list, counters and output register
module lru_datapath
  import lru_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  input  logic [REF_W-1:0]   page_ref,
  input  lru_cmd_t           cmd,
  output lru_status_t        status,
  input  logic               m_axis_tready,
  output logic               m_axis_tvalid,
  output logic [OUT_W-1:0]   m_axis_tdata
);

  localparam int IDX_W = $clog2(FRAMES);
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  logic [LIMIT_W-1:0]   frame_limit;
  logic [PAGE_BITS-1:0] page;
  logic [IDX_W-1:0]     recency [FRAMES];
  logic [CNT_W-1:0]     occupied;
  logic [FAULT_W-1:0]   fault_counter;

  // page store, one read port for the scan, one write port at commit
  logic [PAGE_BITS-1:0] pages [FRAMES];
  logic [IDX_W-1:0]     raddr;
  logic [PAGE_BITS-1:0] rdata;

  // scan pipeline
  logic [CNT_W-1:0]     rpos;
  logic                 cmp_valid;
  logic [CNT_W-1:0]     cmp_pos;
  logic [IDX_W-1:0]     cmp_frame;
  logic                 issue;
  logic [IDX_W-1:0]     rd_idx;
  logic                 match;
  logic                 last;

  // scan result
  logic                 hit_r;
  logic [CNT_W-1:0]     last_pos;
  logic [IDX_W-1:0]     last_frame;
  logic [PAGE_BITS-1:0] last_page;

  // output register
  logic                 out_hit;
  logic                 out_evicted_valid;
  logic [REF_W-1:0]     out_evicted_page;
  logic [COUNT_W-1:0]   out_resident_count;
  logic [FAULT_W-1:0]   out_fault_total;

  logic [PAGE_BITS+REF_W-1:0] ref_ext;
  logic [PAGE_BITS+REF_W-1:0] ev_ext;
  logic [LIM_W-1:0]     lim_ext;
  logic [LIM_W-1:0]     eff_limit;
  logic                 miss;
  logic                 evict;
  logic                 fill;
  logic [CNT_W-1:0]     move_pos;
  logic [IDX_W-1:0]     move_frame;
  logic [CNT_W-1:0]     occupied_next;
  logic [FAULT_W-1:0]   fault_next;

  assign ref_ext = {{PAGE_BITS{1'b0}}, page_ref};
  assign ev_ext  = {{REF_W{1'b0}}, last_page};

  // limit of zero acts as one, above the frame count acts as the frame count
  assign lim_ext   = LIM_W'(frame_limit);
  assign eff_limit = (frame_limit == '0) ? LIM_W'(1) :
                     (lim_ext > LIM_W'(FRAMES)) ? LIM_W'(FRAMES) : lim_ext;

  assign miss  = !hit_r;
  assign evict = miss && (LIM_W'(occupied) >= eff_limit);
  assign fill  = miss && !evict;

  // hit or evict moves the found entry to the front, a fill puts the new frame there
  assign move_pos   = fill ? occupied : last_pos;
  assign move_frame = fill ? occupied[IDX_W-1:0] : last_frame;

  assign occupied_next = fill ? occupied + CNT_W'(1) : occupied;
  assign fault_next    = (miss && !(&fault_counter)) ? fault_counter + FAULT_W'(1)
                                                     : fault_counter;

  assign issue  = rpos < occupied;
  assign rd_idx = issue ? rpos[IDX_W-1:0] : '0;
  assign raddr  = recency[rd_idx];
  assign match  = cmp_valid && (rdata == page);
  assign last   = cmp_valid && (cmp_pos == occupied - CNT_W'(1));

  assign status.scan_done = match || last || (occupied == '0);
  assign status.out_free  = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    rdata <= pages[raddr];
    if (cmd.commit && miss) begin
      pages[move_frame] <= page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit   <= LIMIT_RESET;
      occupied      <= '0;
      fault_counter <= '0;
      cmp_valid     <= 1'b0;
      rpos          <= '0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        recency[i] <= IDX_W'(i);
      end
    end else begin
      if (cfg_wr_en) begin
        frame_limit <= cfg_wr_data;
      end
      if (cmd.load) begin
        rpos      <= '0;
        cmp_valid <= 1'b0;
      end else if (cmd.scan) begin
        cmp_valid <= issue;
        if (issue) begin
          rpos <= rpos + CNT_W'(1);
        end
      end
      if (cmd.commit) begin
        occupied      <= occupied_next;
        fault_counter <= fault_next;
        m_axis_tvalid <= 1'b1;
        for (int i = 0; i < FRAMES; i++) begin
          if (i == 0) begin
            recency[i] <= move_frame;
          end else if (CNT_W'(i) <= move_pos) begin
            recency[i] <= recency[i-1];
          end
        end
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page <= ref_ext[PAGE_BITS-1:0];
    end
    if (cmd.scan) begin
      cmp_pos   <= rpos;
      cmp_frame <= raddr;
      if (status.scan_done) begin
        hit_r      <= match;
        last_pos   <= cmp_pos;
        last_frame <= cmp_frame;
        last_page  <= rdata;
      end
    end
    if (cmd.commit) begin
      out_hit            <= hit_r;
      out_evicted_valid  <= evict;
      out_evicted_page   <= evict ? ev_ext[REF_W-1:0] : '0;
      out_resident_count <= occupied_next[COUNT_W-1:0];
      out_fault_total    <= fault_next;
    end
  end

  assign m_axis_tdata = {2'b00, out_fault_total, out_resident_count, out_evicted_page,
                         out_evicted_valid, out_hit};

endmodule
